// ===== hdl/sha256_pkg.sv =====
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int WordW = 32;
  localparam int CountW = 61;

  typedef logic [WordW-1:0] word_t;

  localparam logic [CountW-1:0] CountMask = {CountW{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push;       // write push_word into the block buffer
    logic [2:0] push_sel;   // which word to push
    logic       cmp_start;  // load round registers from chain values
    logic       round_en;   // run one round
    logic       cmp_done;   // add round registers into chain values
    logic       reinit;     // restore initial hash and count
    logic       count_add;  // add message bytes to the count
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] fill;
    logic [5:0] round;
    logic       tail_is_full;
  } sha_stat_t;

  localparam logic [2:0] PushData = 3'd0;
  localparam logic [2:0] PushZero = 3'd1;
  localparam logic [2:0] PushLenHi = 3'd2;
  localparam logic [2:0] PushLenLo = 3'd3;
  localparam logic [2:0] PushPad = 3'd4;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word_t ror32(input word_t x, input int n);
    ror32 = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ===== hdl/sha256_if.sv =====
`timescale 1ns / 1ps
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// ===== hdl/sha256_datapath.sv =====
`timescale 1ns / 1ps
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha_cmd_t    cmd,
  input  logic [31:0] in_data,
  input  logic [2:0]  in_nv,
  input  logic        in_last,
  input  logic        hold_load,
  input  logic [2:0]  rd_idx,
  output word_t       rd_word,
  output sha_stat_t   stat
);

  word_t             chain_r [8];
  word_t             blk_r [16];
  word_t             rr_r [8];
  logic [CountW-1:0] count_r;
  logic [3:0]        fill_r;
  logic [5:0]        round_r;
  logic [31:0]       hold_data_r;
  logic [2:0]        hold_nv_r;
  logic              hold_last_r;

  logic [2:0]        nv;
  word_t             tail_word;
  word_t             push_word;
  logic [63:0]       bits;
  logic [3:0]        t;
  word_t             x15, x2, sg0, sg1, w_new, w;
  word_t             bs1, ch, t1, bs0, mj;

  always_comb begin
    nv = (hold_nv_r > 3'd4) ? 3'd4 : hold_nv_r;
    if (!hold_last_r || nv == 3'd4) begin
      tail_word = hold_data_r;
    end else if (nv == 3'd0) begin
      tail_word = 32'h8000_0000;
    end else begin
      tail_word = (hold_data_r & (32'hFFFF_FFFF << (6'd32 - {nv, 3'b000})))
                | (32'h80 << (6'd24 - {nv, 3'b000}));
    end
    bits = {count_r, 3'b000};
    case (cmd.push_sel)
      PushData:  push_word = tail_word;
      PushZero:  push_word = 32'h0;
      PushLenHi: push_word = bits[63:32];
      PushLenLo: push_word = bits[31:0];
      PushPad:   push_word = 32'h8000_0000;
      default:   push_word = 32'h0;
    endcase
  end

  // Message schedule and one compression round.
  always_comb begin
    t   = round_r[3:0];
    x15 = blk_r[t + 4'd1];
    x2  = blk_r[t + 4'd14];
    sg0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
    sg1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
    w_new = blk_r[t] + sg0 + blk_r[t + 4'd9] + sg1;
    w   = (round_r >= 6'd16) ? w_new : blk_r[t];
    bs1 = ror32(rr_r[4], 6) ^ ror32(rr_r[4], 11) ^ ror32(rr_r[4], 25);
    ch  = (rr_r[4] & rr_r[5]) ^ (~rr_r[4] & rr_r[6]);
    t1  = rr_r[7] + bs1 + ch + RoundK[round_r] + w;
    bs0 = ror32(rr_r[0], 2) ^ ror32(rr_r[0], 13) ^ ror32(rr_r[0], 22);
    mj  = (rr_r[0] & rr_r[1]) ^ (rr_r[0] & rr_r[2]) ^ (rr_r[1] & rr_r[2]);
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_data_r <= in_data;
      hold_nv_r   <= in_nv;
      hold_last_r <= in_last;
    end
    if (cmd.push) begin
      blk_r[fill_r] <= push_word;
    end
    if (cmd.cmp_start) begin
      for (int i = 0; i < 8; i++) rr_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      blk_r[t] <= w;
      rr_r[7] <= rr_r[6];
      rr_r[6] <= rr_r[5];
      rr_r[5] <= rr_r[4];
      rr_r[4] <= rr_r[3] + t1;
      rr_r[3] <= rr_r[2];
      rr_r[2] <= rr_r[1];
      rr_r[1] <= rr_r[0];
      rr_r[0] <= t1 + bs0 + mj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= InitH[i];
      count_r <= '0;
      fill_r  <= '0;
      round_r <= '0;
    end else begin
      if (cmd.count_add) begin
        count_r <= (count_r + (hold_last_r ? {{(CountW-3){1'b0}}, nv}
                                           : CountW'(4))) & CountMask;
      end
      if (cmd.push) fill_r <= fill_r + 4'd1;
      if (cmd.cmp_start) round_r <= '0;
      else if (cmd.round_en) round_r <= round_r + 6'd1;
      if (cmd.cmp_done) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + rr_r[i];
      end
    end
  end

  assign rd_word = chain_r[rd_idx];
  assign stat.fill = fill_r;
  assign stat.round = round_r;
  assign stat.tail_is_full = hold_last_r && (nv == 3'd4);

endmodule

// ===== hdl/sha256_ctrl.sv =====
`timescale 1ns / 1ps
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      in_last,
  input  logic      out_ready,
  input  sha_stat_t stat,
  output sha_cmd_t  cmd,
  output logic      in_ready,
  output logic      out_valid,
  output logic [2:0] out_idx
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPush  = 4'd1;
  localparam logic [3:0] StComp  = 4'd2;
  localparam logic [3:0] StRound = 4'd3;
  localparam logic [3:0] StAdd   = 4'd4;
  localparam logic [3:0] StPad   = 4'd5;
  localparam logic [3:0] StOut   = 4'd6;
  localparam logic [3:0] StLen   = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       last_r, last_nxt;       // current item ends the message
  logic       extra_r, extra_nxt;     // a 0x80 word is still to push
  logic       done_r, done_nxt;       // the block being compressed carries the length
  logic [2:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    extra_nxt = extra_r;
    done_nxt  = done_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      StIdle: begin
        if (in_fire) begin
          last_nxt  = in_last;
          state_nxt = StPush;
        end
      end
      StPush: begin
        cmd.push = 1'b1;
        cmd.push_sel = PushData;
        cmd.count_add = 1'b1;
        extra_nxt = stat.tail_is_full;
        if (stat.fill == 4'd15) state_nxt = StComp;
        else if (last_r) state_nxt = StPad;
        else state_nxt = StIdle;
      end
      StComp: begin
        cmd.cmp_start = 1'b1;
        state_nxt = StRound;
      end
      StRound: begin
        cmd.round_en = 1'b1;
        if (stat.round == 6'd63) state_nxt = StAdd;
      end
      StAdd: begin
        cmd.cmp_done = 1'b1;
        if (last_r && done_r) begin
          // The length block finished: go and emit the digest.
          state_nxt = StOut;
          idx_nxt   = '0;
          done_nxt  = 1'b0;
        end else if (last_r) begin
          state_nxt = StPad;
        end else begin
          state_nxt = StIdle;
        end
      end
      StPad: begin
        // After a final data word: 0x80 word if needed, zeros up to word 14,
        // then the two length words.
        cmd.push = 1'b1;
        if (extra_r) begin
          cmd.push_sel = PushPad;
          extra_nxt = 1'b0;
          if (stat.fill == 4'd15) state_nxt = StComp;
        end else if (stat.fill == 4'd14) begin
          cmd.push_sel = PushLenHi;
          state_nxt = StLen;
        end else begin
          cmd.push_sel = PushZero;
          if (stat.fill == 4'd15) state_nxt = StComp;
        end
      end
      StLen: begin
        cmd.push = 1'b1;
        cmd.push_sel = PushLenLo;
        done_nxt = 1'b1;
        state_nxt = StComp;
      end
      StOut: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.reinit = 1'b1;
            state_nxt = StIdle;
          end
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      last_r  <= 1'b0;
      extra_r <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      extra_r <= extra_nxt;
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_ready  = (state_r == StIdle);
  assign out_valid = (state_r == StOut);
  assign out_idx   = idx_r;

endmodule

// ===== hdl/sha256_message_digest.sv =====
`timescale 1ns / 1ps
// A word that does not fill a block is pushed and the input is ready again; one that fills it
// is compressed with one round per cycle over 64 rounds, set by the single round unit.
// The input is not ready while a word is pushed, padded or compressed, or while the digest is out.
// The last item adds the padding words and one or two compressions,
// then eight digest items follow, one per cycle when the sink is ready.
// Reset (synchronous, active low) restores the initial hash and a zero count.
module sha256_message_digest
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sha256_in_if.sink   in_ch,
  sha256_out_if.source out_ch
);

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic      in_fire;
  logic [2:0] idx;

  assign in_fire = in_ch.valid && in_ch.ready;

  // The controller sequences pushes, padding, rounds and digest output.
  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_ch.last_word),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_idx   (idx)
  );

  // The datapath holds the chain values, block buffer and round registers.
  sha256_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_ch.data_word),
    .in_nv     (in_ch.valid_bytes),
    .in_last   (in_ch.last_word),
    .hold_load (in_fire),
    .rd_idx    (idx),
    .rd_word   (out_ch.digest_word),
    .stat      (stat)
  );

  assign out_ch.word_index  = idx;
  assign out_ch.digest_last = (idx == 3'd7);

endmodule

// ===== hdl/sha256_checker.sv =====
`timescale 1ns / 1ps
module sha256_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] word_index,
  input logic       digest_last
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during digest output");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("input ready right after an item");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (digest_last == (word_index == 3'd7))) else $error("bad last flag");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !digest_last) |=> (out_valid &&
      word_index == $past(word_index) + 3'd1)) else $error("index skipped");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
    else $error("output dropped");

endmodule

bind sha256_message_digest sha256_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .word_index  (out_ch.word_index),
  .digest_last (out_ch.digest_last)
);
